// ===== rtl/pbsb_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsb_pkg
// Shared constants for the projected box screen bounds block: default
// coordinate format, coefficient word width, register map and reset values.
// ----------------------------------------------------------------------------
package pbsb_pkg;

  localparam int DEF_COORD_BITS    = 32;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int COEF_BITS  = 32;
  localparam int NUM_REGS   = 6;
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ROW_X_01 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_X_23 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y_01 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y_23 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW_W_01 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW_W_23 = 3'd5;

  localparam logic [APB_DATA_W-1:0] RST_ROW_X_01 = 64'h0000_0001_0000_0000;
  localparam logic [APB_DATA_W-1:0] RST_ROW_X_23 = 64'h0000_0000_0000_0000;
  localparam logic [APB_DATA_W-1:0] RST_ROW_Y_01 = 64'h0001_0000_0000_0000;
  localparam logic [APB_DATA_W-1:0] RST_ROW_Y_23 = 64'h0000_0000_0000_0000;
  localparam logic [APB_DATA_W-1:0] RST_ROW_W_01 = 64'h0000_0000_0000_0000;
  localparam logic [APB_DATA_W-1:0] RST_ROW_W_23 = 64'h0000_0000_0001_0000;

endpackage

// ===== rtl/projected_box_screen_bounds.sv =====
// ----------------------------------------------------------------------------
// projected_box_screen_bounds
// Projects box corners through the x, y and w rows of a programmable matrix,
// divides x and y by w and tracks the screen-space rectangle of each box.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                        Direction
//   corner    corner_valid/ready, corner_x/y/z, last_corner   in
//   rect      rect_valid/ready, rect_min/max_x/y, saturated   out
//   config    psel, penable, pwrite, paddr, pwdata, prdata    APB slave
//
// A corner passes through one shared multiplier used nine times and one
// restoring divider producing a quotient bit per cycle, used twice; a
// division with a zero divisor or an out-of-range result skips the bit loop.
// No new corner is taken until the current one has been processed.
// Reset is synchronous and returns the matrix and the running rectangle to
// their defaults. A finished rectangle waits in the output register while the
// next corners are processed; only a later last corner stalls behind it.
module projected_box_screen_bounds
  import pbsb_pkg::*;
#(
  parameter int COORD_BITS    = DEF_COORD_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready,
  input  logic                         corner_valid,
  output logic                         corner_ready,
  input  logic signed [COORD_BITS-1:0] corner_x,
  input  logic signed [COORD_BITS-1:0] corner_y,
  input  logic signed [COORD_BITS-1:0] corner_z,
  input  logic                         last_corner,
  output logic                         rect_valid,
  input  logic                         rect_ready,
  output logic signed [COORD_BITS-1:0] rect_min_x,
  output logic signed [COORD_BITS-1:0] rect_min_y,
  output logic signed [COORD_BITS-1:0] rect_max_x,
  output logic signed [COORD_BITS-1:0] rect_max_y,
  output logic                         saturated
);

  localparam int ACC_W  = ((COORD_BITS + 32 > FRACTION_BITS + 31) ?
                           COORD_BITS + 32 : FRACTION_BITS + 31) + 2;
  localparam int PROD_W = COEF_BITS + COORD_BITS;
  localparam int NUM_W  = ACC_W + FRACTION_BITS;
  localparam int CMP_W  = ACC_W + FRACTION_BITS + COORD_BITS;
  localparam int CNT_W  = $clog2(COORD_BITS);
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] MAC_DONE = 4'd9;

  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_W = 2'd2;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MAC    = 7'b0000010,
    S_PREP   = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_QUOT   = 7'b0100000,
    S_UPDATE = 7'b1000000
  } state_t;

  state_t state;

  logic [APB_DATA_W-1:0] row_x_01, row_x_23, row_y_01, row_y_23, row_w_01, row_w_23;

  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic                         last_reg;

  logic [STEP_W-1:0]        step;
  logic signed [COEF_BITS-1:0]  mul_a;
  logic signed [COORD_BITS-1:0] mul_b;
  logic [1:0]               mul_row;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_en;
  logic [1:0]               prod_row;
  logic [ACC_W-1:0]         prod_ext;
  logic [ACC_W-1:0]         p_x, p_y, p_w;

  logic                   div_sel;
  logic [ACC_W-1:0]       num_sel;
  logic                   n_neg, d_neg;
  logic [ACC_W-1:0]       n_mag, d_mag;
  logic [NUM_W-1:0]       num_full;
  logic [NUM_W-1:0]       num_top;
  logic [CMP_W-1:0]       cmp_num, cmp_den;
  logic                   den_zero, ovf;
  logic [ACC_W-1:0]       rem;
  logic [COORD_BITS-1:0]  nlow;
  logic [COORD_BITS-1:0]  quot;
  logic [CNT_W-1:0]       cnt;
  logic [ACC_W:0]         rem_sh;
  logic [ACC_W+1:0]       diff;
  logic                   ge;

  logic                         q_neg, q_big, res_sat;
  logic signed [COORD_BITS-1:0] res;
  logic signed [COORD_BITS-1:0] sx, sy;

  logic signed [COORD_BITS-1:0] running_min_x, running_min_y;
  logic signed [COORD_BITS-1:0] running_max_x, running_max_y;
  logic                         saturation_seen;
  logic signed [COORD_BITS-1:0] min_x_next, min_y_next, max_x_next, max_y_next;

  logic cfg_write;
  logic out_free;
  logic rect_load;

  function automatic logic [ACC_W-1:0] bias(input logic [COEF_BITS-1:0] c);
    bias = {{(ACC_W-COEF_BITS-FRACTION_BITS){c[COEF_BITS-1]}}, c,
            {FRACTION_BITS{1'b0}}};
  endfunction

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x_01 <= RST_ROW_X_01;
      row_x_23 <= RST_ROW_X_23;
      row_y_01 <= RST_ROW_Y_01;
      row_y_23 <= RST_ROW_Y_23;
      row_w_01 <= RST_ROW_W_01;
      row_w_23 <= RST_ROW_W_23;
    end else if (cfg_write) begin
      case (paddr[APB_ADDR_W-1:3])
        REG_ROW_X_01: row_x_01 <= pwdata;
        REG_ROW_X_23: row_x_23 <= pwdata;
        REG_ROW_Y_01: row_y_01 <= pwdata;
        REG_ROW_Y_23: row_y_23 <= pwdata;
        REG_ROW_W_01: row_w_01 <= pwdata;
        REG_ROW_W_23: row_w_23 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_ADDR_W-1:3])
      REG_ROW_X_01: prdata = row_x_01;
      REG_ROW_X_23: prdata = row_x_23;
      REG_ROW_Y_01: prdata = row_y_01;
      REG_ROW_Y_23: prdata = row_y_23;
      REG_ROW_W_01: prdata = row_w_01;
      REG_ROW_W_23: prdata = row_w_23;
      default:      prdata = '0;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (step)
      4'd0:    begin mul_a = row_x_01[31:0];  mul_b = cx; mul_row = ROW_X; end
      4'd1:    begin mul_a = row_x_01[63:32]; mul_b = cy; mul_row = ROW_X; end
      4'd2:    begin mul_a = row_x_23[31:0];  mul_b = cz; mul_row = ROW_X; end
      4'd3:    begin mul_a = row_y_01[31:0];  mul_b = cx; mul_row = ROW_Y; end
      4'd4:    begin mul_a = row_y_01[63:32]; mul_b = cy; mul_row = ROW_Y; end
      4'd5:    begin mul_a = row_y_23[31:0];  mul_b = cz; mul_row = ROW_Y; end
      4'd6:    begin mul_a = row_w_01[31:0];  mul_b = cx; mul_row = ROW_W; end
      4'd7:    begin mul_a = row_w_01[63:32]; mul_b = cy; mul_row = ROW_W; end
      4'd8:    begin mul_a = row_w_23[31:0];  mul_b = cz; mul_row = ROW_W; end
      default: begin mul_a = '0;              mul_b = '0; mul_row = ROW_X; end
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // Divider datapath.
  assign num_sel  = div_sel ? p_y : p_x;
  assign num_full = {n_mag, {FRACTION_BITS{1'b0}}};
  assign num_top  = num_full >> COORD_BITS;
  assign cmp_num  = {{COORD_BITS{1'b0}}, num_full};
  assign cmp_den  = {{FRACTION_BITS{1'b0}}, d_mag, {COORD_BITS{1'b0}}};
  assign rem_sh   = {rem, nlow[COORD_BITS-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, d_mag};
  assign ge       = !diff[ACC_W+1];

  assign q_neg = n_neg ^ d_neg;
  assign q_big = q_neg ? (quot[COORD_BITS-1] && (|quot[COORD_BITS-2:0]))
                       : quot[COORD_BITS-1];

  always_comb begin
    if (den_zero) begin
      res_sat = 1'b1;
      if (n_mag == '0) begin
        res = '0;
      end else begin
        res = n_neg ? COORD_MIN : COORD_MAX;
      end
    end else if (ovf || q_big) begin
      res_sat = 1'b1;
      res     = q_neg ? COORD_MIN : COORD_MAX;
    end else begin
      res_sat = 1'b0;
      res     = q_neg ? $signed(~quot + 1'b1) : $signed(quot);
    end
  end

  assign min_x_next = (sx < running_min_x) ? sx : running_min_x;
  assign min_y_next = (sy < running_min_y) ? sy : running_min_y;
  assign max_x_next = (sx > running_max_x) ? sx : running_max_x;
  assign max_y_next = (sy > running_max_y) ? sy : running_max_y;

  assign out_free     = !rect_valid || rect_ready;
  assign corner_ready = (state == S_IDLE);
  assign rect_load    = (state == S_UPDATE) && last_reg && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      prod_en         <= 1'b0;
      rect_valid      <= 1'b0;
      running_min_x   <= COORD_MAX;
      running_min_y   <= COORD_MAX;
      running_max_x   <= COORD_MIN;
      running_max_y   <= COORD_MIN;
      saturation_seen <= 1'b0;
    end else begin
      if (rect_load) begin
        rect_valid <= 1'b1;
      end else if (rect_valid && rect_ready) begin
        rect_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (corner_valid) begin
            cx       <= corner_x;
            cy       <= corner_y;
            cz       <= corner_z;
            last_reg <= last_corner;
            p_x      <= bias(row_x_23[63:32]);
            p_y      <= bias(row_y_23[63:32]);
            p_w      <= bias(row_w_23[63:32]);
            step     <= '0;
            prod_en  <= 1'b0;
            state    <= S_MAC;
          end
        end
        S_MAC: begin
          if (prod_en) begin
            case (prod_row)
              ROW_X:   p_x <= p_x + prod_ext;
              ROW_Y:   p_y <= p_y + prod_ext;
              default: p_w <= p_w + prod_ext;
            endcase
          end
          if (step == MAC_DONE) begin
            prod_en <= 1'b0;
            div_sel <= 1'b0;
            state   <= S_PREP;
          end else begin
            prod     <= mul_a * mul_b;
            prod_row <= mul_row;
            prod_en  <= 1'b1;
            step     <= step + 1'b1;
          end
        end
        S_PREP: begin
          n_neg <= num_sel[ACC_W-1];
          n_mag <= num_sel[ACC_W-1] ? (~num_sel + 1'b1) : num_sel;
          d_neg <= p_w[ACC_W-1];
          d_mag <= p_w[ACC_W-1] ? (~p_w + 1'b1) : p_w;
          state <= S_CHECK;
        end
        S_CHECK: begin
          den_zero <= (d_mag == '0);
          ovf      <= (cmp_num >= cmp_den);
          rem      <= num_top[ACC_W-1:0];
          nlow     <= num_full[COORD_BITS-1:0];
          quot     <= '0;
          cnt      <= '0;
          if ((d_mag == '0) || (cmp_num >= cmp_den)) begin
            state <= S_QUOT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
          quot <= {quot[COORD_BITS-2:0], ge};
          nlow <= nlow << 1;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(COORD_BITS - 1)) begin
            state <= S_QUOT;
          end
        end
        S_QUOT: begin
          if (res_sat) begin
            saturation_seen <= 1'b1;
          end
          if (div_sel) begin
            sy    <= res;
            state <= S_UPDATE;
          end else begin
            sx      <= res;
            div_sel <= 1'b1;
            state   <= S_PREP;
          end
        end
        S_UPDATE: begin
          if (!last_reg) begin
            running_min_x <= min_x_next;
            running_min_y <= min_y_next;
            running_max_x <= max_x_next;
            running_max_y <= max_y_next;
            state         <= S_IDLE;
          end else if (out_free) begin
            rect_min_x      <= min_x_next;
            rect_min_y      <= min_y_next;
            rect_max_x      <= max_x_next;
            rect_max_y      <= max_y_next;
            saturated       <= saturation_seen;
            running_min_x   <= COORD_MAX;
            running_min_y   <= COORD_MAX;
            running_max_x   <= COORD_MIN;
            running_max_y   <= COORD_MIN;
            saturation_seen <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pbsb_checker.sv =====
// ----------------------------------------------------------------------------
// pbsb_checker
// Port-level checks for the projected box screen bounds block, attached to
// the top level by a bind statement.
// ----------------------------------------------------------------------------
module pbsb_checker
  import pbsb_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         corner_valid,
  input logic                         corner_ready,
  input logic                         rect_valid,
  input logic                         rect_ready,
  input logic signed [COORD_BITS-1:0] rect_min_x,
  input logic signed [COORD_BITS-1:0] rect_min_y,
  input logic signed [COORD_BITS-1:0] rect_max_x,
  input logic signed [COORD_BITS-1:0] rect_max_y,
  input logic                         saturated
);

  // The block comes out of reset idle with no pending transaction.
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> corner_ready && !rect_valid)
    else $error("block not idle after reset");

  // An accepted corner leaves the block busy, so corner_ready drops after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    corner_valid && corner_ready |=> !corner_ready)
    else $error("corner accepted while previous corner in progress");

  // Every rectangle contains at least one projected corner.
  a_rect_ordered: assert property (@(posedge clk) disable iff (rst)
    rect_valid |-> (rect_min_x <= rect_max_x) && (rect_min_y <= rect_max_y))
    else $error("rectangle minimum exceeds maximum");

  // A new rectangle only follows the processing of a corner.
  a_rect_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rect_valid) |-> $past(!corner_ready))
    else $error("rectangle appeared without corner processing");

  // A stalled rectangle holds its value.
  a_rect_hold: assert property (@(posedge clk) disable iff (rst)
    rect_valid && !rect_ready |=> rect_valid && $stable(rect_min_x) &&
      $stable(rect_min_y) && $stable(rect_max_x) && $stable(rect_max_y) &&
      $stable(saturated))
    else $error("stalled rectangle changed");

endmodule

bind projected_box_screen_bounds pbsb_checker #(.COORD_BITS(COORD_BITS)) u_pbsb_checker (
  .clk          (clk),
  .rst          (rst),
  .corner_valid (corner_valid),
  .corner_ready (corner_ready),
  .rect_valid   (rect_valid),
  .rect_ready   (rect_ready),
  .rect_min_x   (rect_min_x),
  .rect_min_y   (rect_min_y),
  .rect_max_x   (rect_max_x),
  .rect_max_y   (rect_max_y),
  .saturated    (saturated)
);

// ===== sim/tb_projected_box_screen_bounds.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_projected_box_screen_bounds
// Self-checking bench for the projected box screen bounds block. A scoreboard
// projects each accepted corner through its own copy of the matrix, keeps the
// running rectangle and queues the rectangle expected on every last corner.
// The run covers directed corner cases and random boxes under several
// matrices, with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_projected_box_screen_bounds;
  import pbsb_pkg::*;

  localparam int CW              = DEF_COORD_BITS;
  localparam int FW              = DEF_FRACTION_BITS;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 8;
  localparam int SETTLE_CYCLES   = 200;
  localparam int STALL_LIMIT     = 5000;
  localparam int HEAVY_PCT       = 69;
  localparam int BOTH_PCT        = 30;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [127:0]  wide_t;
  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
    logic   sat;
  } rect_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t Q_ONE     = coord_t'(1) <<< FW;

  class screen_rect_board;
    logic [APB_DATA_W-1:0] coef [NUM_REGS];
    coord_t lo_x, lo_y, hi_x, hi_y;
    bit     sat_seen;
    rect_t  pending_rects [$];
    int     mismatches;

    function new();
      coef[REG_ROW_X_01] = RST_ROW_X_01;
      coef[REG_ROW_X_23] = RST_ROW_X_23;
      coef[REG_ROW_Y_01] = RST_ROW_Y_01;
      coef[REG_ROW_Y_23] = RST_ROW_Y_23;
      coef[REG_ROW_W_01] = RST_ROW_W_01;
      coef[REG_ROW_W_23] = RST_ROW_W_23;
      mismatches = 0;
      clear_box();
    endfunction

    function void clear_box();
      lo_x = COORD_MAX;
      lo_y = COORD_MAX;
      hi_x = COORD_MIN;
      hi_y = COORD_MIN;
      sat_seen = 1'b0;
    endfunction

    function void set_coef(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
      coef[idx] = val;
    endfunction

    // Exact dot product of one matrix row with (x, y, z, 1.0).
    function wide_t row_dot(logic [APB_DATA_W-1:0] c01, logic [APB_DATA_W-1:0] c23,
                            coord_t x, coord_t y, coord_t z);
      wide_t k0, k1, k2, k3;
      k0 = $signed(c01[COEF_BITS-1:0]);
      k1 = $signed(c01[2*COEF_BITS-1:COEF_BITS]);
      k2 = $signed(c23[COEF_BITS-1:0]);
      k3 = $signed(c23[2*COEF_BITS-1:COEF_BITS]);
      return k0 * x + k1 * y + k2 * z + (k3 <<< FW);
    endfunction

    // Quotient scaled to the coordinate format, truncated toward zero and
    // saturated on a zero divisor or an out-of-range result.
    function coord_t ratio(wide_t num, wide_t den, output bit sat);
      logic [127:0] n, d, q, lim;
      bit neg;
      sat = 1'b0;
      n = num[127] ? -num : num;
      d = den[127] ? -den : den;
      neg = num[127] ^ den[127];
      if (d == '0) begin
        sat = 1'b1;
        if (n == '0) return '0;
        return num[127] ? COORD_MIN : COORD_MAX;
      end
      q = (n << FW) / d;
      lim = neg ? (128'd1 << (CW - 1)) : (128'd1 << (CW - 1)) - 128'd1;
      if (q > lim) begin
        sat = 1'b1;
        return neg ? COORD_MIN : COORD_MAX;
      end
      return neg ? -q[CW-1:0] : q[CW-1:0];
    endfunction

    function void add_corner(coord_t x, coord_t y, coord_t z, logic last);
      wide_t  px, py, pw;
      coord_t sx, sy;
      bit     sat_x, sat_y;
      rect_t  box_rect;
      px = row_dot(coef[REG_ROW_X_01], coef[REG_ROW_X_23], x, y, z);
      py = row_dot(coef[REG_ROW_Y_01], coef[REG_ROW_Y_23], x, y, z);
      pw = row_dot(coef[REG_ROW_W_01], coef[REG_ROW_W_23], x, y, z);
      sx = ratio(px, pw, sat_x);
      sy = ratio(py, pw, sat_y);
      if (sx < lo_x) lo_x = sx;
      if (sy < lo_y) lo_y = sy;
      if (sx > hi_x) hi_x = sx;
      if (sy > hi_y) hi_y = sy;
      if (sat_x || sat_y) sat_seen = 1'b1;
      if (last) begin
        box_rect = '{lo_x, lo_y, hi_x, hi_y, sat_seen};
        pending_rects = {pending_rects, box_rect};
        clear_box();
      end
    endfunction

    function void compare(string field, coord_t want, coord_t got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void take_rect(rect_t got);
      rect_t want;
      if (pending_rects.size() == 0) begin
        $error("rect transaction with no box outstanding");
        mismatches++;
        return;
      end
      want = pending_rects.pop_front();
      compare("rect_min_x", want.min_x, got.min_x);
      compare("rect_min_y", want.min_y, got.min_y);
      compare("rect_max_x", want.max_x, got.max_x);
      compare("rect_max_y", want.max_y, got.max_y);
      compare("saturated", coord_t'(want.sat), coord_t'(got.sat));
    endfunction

    function int pending();
      return pending_rects.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  corner_valid = 1'b0;
  logic                  corner_ready;
  coord_t                corner_x = '0;
  coord_t                corner_y = '0;
  coord_t                corner_z = '0;
  logic                  last_corner = 1'b0;
  logic                  rect_valid;
  logic                  rect_ready = 1'b0;
  coord_t                rect_min_x;
  coord_t                rect_min_y;
  coord_t                rect_max_x;
  coord_t                rect_max_y;
  logic                  saturated;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;
  int quiet_cycles = 0;

  screen_rect_board board;

  projected_box_screen_bounds u_dut (.*);

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rect_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_stall_pct > 0 && $urandom_range(31) == 0) begin
      rect_ready <= 1'b0;
      rx_hold <= $urandom_range(1, 150);
    end else begin
      rect_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (corner_valid && corner_ready) begin
        board.add_corner(corner_x, corner_y, corner_z, last_corner);
      end
      if (rect_valid && rect_ready) begin
        board.take_rect(rect_t'{rect_min_x, rect_min_y, rect_max_x, rect_max_y, saturated});
      end
      if ((corner_valid && corner_ready) || (rect_valid && rect_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL projected_box_screen_bounds");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic coord_t small_q();
    return coord_t'($urandom_range(0, 32'h0080_0000)) - coord_t'(32'h0040_0000);
  endfunction

  function automatic coord_t pick_coord();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 60) return small_q();
    if (k < 85) return coord_t'($urandom);
    case ($urandom_range(4))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return Q_ONE;
      default: return -Q_ONE;
    endcase
  endfunction

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = APB_ADDR_W'({idx, 3'b000});
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_coef(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic configure(int phase);
    logic [APB_DATA_W-1:0] words [NUM_REGS];
    logic [COEF_BITS-1:0]  f;
    f = 32'h0000_8000 + $urandom_range(0, 32'h0003_8000);
    case (phase)
      1, 6: begin
        words[REG_ROW_X_01] = {32'h0, f};
        words[REG_ROW_X_23] = {small_q(), small_q()};
        words[REG_ROW_Y_01] = {f, 32'h0};
        words[REG_ROW_Y_23] = {small_q(), small_q()};
        words[REG_ROW_W_01] = '0;
        words[REG_ROW_W_23] = (phase == 1) ? {32'h0, 32'hFFFF_0000}
                                           : {32'h0001_0000, 32'h0001_0000};
      end
      2: begin
        foreach (words[i]) words[i] = '1;
      end
      3: begin
        words[REG_ROW_X_01] = 64'h8000_0000_8000_0000;
        words[REG_ROW_X_23] = 64'h8000_0000_8000_0000;
        words[REG_ROW_Y_01] = 64'h8000_0000_8000_0000;
        words[REG_ROW_Y_23] = 64'h8000_0000_8000_0000;
        words[REG_ROW_W_01] = 64'h7FFF_FFFF_7FFF_FFFF;
        words[REG_ROW_W_23] = 64'h7FFF_FFFF_7FFF_FFFF;
      end
      5: begin
        foreach (words[i]) words[i] = {$urandom, $urandom};
        words[REG_ROW_W_01] = '0;
        words[REG_ROW_W_23] = '0;
      end
      7: begin
        foreach (words[i]) words[i] = {small_q(), small_q()};
      end
      default: begin
        foreach (words[i]) words[i] = {$urandom, $urandom};
      end
    endcase
    for (int i = 0; i < NUM_REGS; i++) reg_write(REG_IDX_W'(i), words[i]);
  endtask

  task automatic send_corner(coord_t x, coord_t y, coord_t z, bit last);
    @(negedge clk);
    if (tx_idle_pct > 0 && $urandom_range(15) == 0) begin
      corner_valid = 1'b0;
      repeat ($urandom_range(1, 90)) @(negedge clk);
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      corner_valid = 1'b0;
      @(negedge clk);
    end
    corner_valid = 1'b1;
    corner_x = x;
    corner_y = y;
    corner_z = z;
    last_corner = last;
    do @(posedge clk); while (!corner_ready);
  endtask

  task automatic run_boxes(int n_items);
    int sent, corners;
    sent = 0;
    while (sent < n_items) begin
      corners = ($urandom_range(9) < 7) ? 8 : $urandom_range(1, 8);
      for (int i = 0; i < corners; i++) begin
        send_corner(pick_coord(), pick_coord(), pick_coord(), i == corners - 1);
      end
      sent += corners;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    corner_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) configure(phase);
      case (phase % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = HEAVY_PCT;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = HEAVY_PCT;
        end
        default: begin
          tx_idle_pct = BOTH_PCT;
          rx_stall_pct = BOTH_PCT;
        end
      endcase

      if (phase == 0) begin
        // With the reset matrix w equals z, so z selects the division cases.
        send_corner('0, '0, '0, 1'b1);
        send_corner('0, Q_ONE, '0, 1'b1);
        send_corner('0, -Q_ONE, '0, 1'b1);
        send_corner(COORD_MAX, COORD_MAX, coord_t'(1), 1'b1);
        send_corner(COORD_MIN, COORD_MIN, coord_t'(1), 1'b1);
        send_corner(Q_ONE, 2 * Q_ONE, -Q_ONE, 1'b1);
        send_corner(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_corner(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_corner(-coord_t'(1), -coord_t'(1), -coord_t'(1), 1'b0);
        send_corner(coord_t'(1), coord_t'(1), coord_t'(1), 1'b1);
        send_corner(coord_t'(32'h0003_8000), -coord_t'(32'h0002_4000),
                    coord_t'(32'h0004_0000), 1'b1);
        send_corner(Q_ONE, Q_ONE, Q_ONE, 1'b0);
        send_corner(Q_ONE, -Q_ONE, '0, 1'b0);
        send_corner(2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE, 1'b1);
        send_corner(Q_ONE, Q_ONE, 2 * Q_ONE, 1'b0);
        send_corner(-Q_ONE, 2 * Q_ONE, Q_ONE, 1'b1);
      end

      run_boxes(ITEMS_PER_PHASE / 2);
      wait_drained();
      run_boxes(ITEMS_PER_PHASE / 2);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (board.mismatches == 0) begin
      $display("PASS projected_box_screen_bounds");
    end else begin
      $display("FAIL projected_box_screen_bounds");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pbsb_pkg.sv
rtl/projected_box_screen_bounds.sv
rtl/pbsb_checker.sv
sim/tb_projected_box_screen_bounds.sv
